@@ src/vsa_pkg.sv @@
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared sizes and controller/datapath handshake types for the voice slot
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vsa_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int TIME_BITS = 32;

   localparam int OP_BITS   = 1;
   localparam int CTIME_BITS = 32;
   localparam int LEN_BITS  = 20;
   localparam int CAT_BITS  = 4;
   localparam int OIDX_BITS = 4;
   localparam int CFG_BITS  = 5;

   localparam int IDX_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_BITS = $clog2(MAX_SLOTS + 1);
   localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int SUM_BITS = ((TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS) + 1;
   localparam int TEXT_BITS = (TIME_BITS > CTIME_BITS) ? TIME_BITS : CTIME_BITS;

   localparam logic [CFG_BITS-1:0] SLOT_COUNT_RESET = CFG_BITS'(16);

   localparam logic [OP_BITS-1:0] OP_REQUEST = 1'b0;
   localparam logic [OP_BITS-1:0] OP_CLEAR   = 1'b1;

   typedef struct packed {
      logic start;
      logic scan_step;
      logic commit;
   } vsa_cmd_type;

   typedef struct packed {
      logic skip_scan;
      logic scan_last;
      logic out_free;
   } vsa_status_type;

endpackage

`default_nettype wire

@@ src/vsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// vsa_ctrl
// Sequencer: accept a request, scan the slot table one entry per cycle
// unless skipped, then commit the slot update and load the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module vsa_ctrl
   import vsa_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  vsa_status_type      status,
   output vsa_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.start     = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               state_in  = status.skip_scan ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/vsa_datapath.sv @@
// ----------------------------------------------------------------------------
// vsa_datapath
// Slot table, request holding registers, scan tracking and the response
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module vsa_datapath
   import vsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [OP_BITS-1:0]    req_opcode,
   input  wire logic [CTIME_BITS-1:0] req_current_time,
   input  wire logic [LEN_BITS-1:0]   req_sound_length,
   input  wire logic [CAT_BITS-1:0]   req_request_category,
   input  wire logic                  req_sound_present,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_BITS-1:0]   csr_wr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_granted,
   output logic [OIDX_BITS-1:0]       rsp_slot_index,
   input  vsa_cmd_type                cmd,
   output vsa_status_type             status
);

   logic [CAT_BITS-1:0]  slot_cat_ff   [MAX_SLOTS];
   logic [TIME_BITS-1:0] slot_start_ff [MAX_SLOTS];
   logic [TIME_BITS-1:0] slot_end_ff   [MAX_SLOTS];

   logic [CFG_BITS-1:0]  slot_count_ff;

   logic [OP_BITS-1:0]   op_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [LEN_BITS-1:0]  len_ff;
   logic [CAT_BITS-1:0]  cat_ff;
   logic                 refuse_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic                 found_ff;
   logic                 have_ff;
   logic [IDX_BITS-1:0]  chosen_ff;
   logic [TIME_BITS-1:0] best_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_granted_ff;
   logic [OIDX_BITS-1:0] rsp_index_ff;

   logic [CNT_BITS-1:0]  eff_count;
   logic [TEXT_BITS-1:0] now_ext;
   logic [TIME_BITS-1:0] now_in;
   logic                 refuse_in;
   logic [CAT_BITS-1:0]  rd_cat;
   logic [TIME_BITS-1:0] rd_start;
   logic [TIME_BITS-1:0] rd_end;
   logic                 hit_free;
   logic                 better;
   logic                 last_idx;
   logic                 grant;
   logic [SUM_BITS-1:0]  end_sum;
   logic [TIME_BITS-1:0] end_time;
   logic [IDX_BITS+OIDX_BITS-1:0] chosen_ext;

   assign eff_count = (CMP_BITS'(slot_count_ff) > CMP_BITS'(MAX_SLOTS))
                      ? CNT_BITS'(MAX_SLOTS) : CNT_BITS'(slot_count_ff);
   assign now_ext   = TEXT_BITS'(req_current_time);
   assign now_in    = now_ext[TIME_BITS-1:0];
   assign refuse_in = !req_sound_present || (eff_count == '0);

   assign rd_cat   = slot_cat_ff[idx_ff];
   assign rd_start = slot_start_ff[idx_ff];
   assign rd_end   = slot_end_ff[idx_ff];
   assign hit_free = (rd_end <= now_ff);
   assign better   = (rd_cat == cat_ff) && (!have_ff || (rd_start < best_ff));
   assign last_idx = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == count_ff);

   assign grant    = (op_ff == OP_REQUEST) && !refuse_ff && (found_ff || have_ff);

   // end time saturates at the top of the time range
   assign end_sum  = SUM_BITS'(now_ff) + SUM_BITS'(len_ff);
   assign end_time = (|end_sum[SUM_BITS-1:TIME_BITS]) ? '1 : end_sum[TIME_BITS-1:0];

   assign chosen_ext = {{OIDX_BITS{1'b0}}, chosen_ff};

   assign status.skip_scan = (req_opcode == OP_CLEAR) || refuse_in;
   assign status.scan_last = hit_free || last_idx;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_slot_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
      end else if (csr_wr_en) begin
         slot_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= req_opcode;
         now_ff    <= now_in;
         len_ff    <= req_sound_length;
         cat_ff    <= req_request_category;
         refuse_ff <= refuse_in;
         count_ff  <= eff_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else if (cmd.start) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IDX_BITS'(1);
         if (hit_free) begin
            found_ff  <= 1'b1;
            chosen_ff <= idx_ff;
         end else if (better) begin
            have_ff   <= 1'b1;
            chosen_ff <= idx_ff;
            best_ff   <= rd_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_cat_ff[i]   <= '0;
            slot_start_ff[i] <= '0;
            slot_end_ff[i]   <= '0;
         end
      end else if (cmd.commit) begin
         if (op_ff == OP_CLEAR) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
               slot_cat_ff[i]   <= '0;
               slot_start_ff[i] <= '0;
               slot_end_ff[i]   <= '0;
            end
         end else if (grant) begin
            slot_cat_ff[chosen_ff]   <= cat_ff;
            slot_start_ff[chosen_ff] <= now_ff;
            slot_end_ff[chosen_ff]   <= end_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_granted_ff <= grant;
         rsp_index_ff   <= grant ? chosen_ext[OIDX_BITS-1:0] : '0;
      end
   end

endmodule

`default_nettype wire

@@ src/voice_slot_allocator_core.sv @@
// ----------------------------------------------------------------------------
// voice_slot_allocator_core
// Voice slot allocator: grants a free slot or steals the oldest slot of the
// same category, and clears the table on request.
// ----------------------------------------------------------------------------
// One request is in work at a time. A slot request scans the table one entry
// per cycle, stopping at the first free entry or after the slot count of
// entries (at most MAX_SLOTS), then commits and loads its response; the next
// request is accepted once the controller is back in idle after the commit.
// A clear, a request with no sound, or a slot count of zero skips the scan and
// goes straight to the commit. The response sits in an output register; the
// next request is accepted while it waits, and the final commit cycle holds
// until that register can be reloaded.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_slot_allocator_core
   import vsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [OP_BITS-1:0]    req_opcode,
   input  wire logic [CTIME_BITS-1:0] req_current_time,
   input  wire logic [LEN_BITS-1:0]   req_sound_length,
   input  wire logic [CAT_BITS-1:0]   req_request_category,
   input  wire logic                  req_sound_present,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_granted,
   output logic [OIDX_BITS-1:0]       rsp_slot_index,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_BITS-1:0]   csr_wr_data
);

   vsa_cmd_type    cmd;
   vsa_status_type status;

   vsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vsa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_opcode           (req_opcode),
      .req_current_time     (req_current_time),
      .req_sound_length     (req_sound_length),
      .req_request_category (req_request_category),
      .req_sound_present    (req_sound_present),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_granted          (rsp_granted),
      .rsp_slot_index       (rsp_slot_index),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

`default_nettype wire
